// File: hw/rtl/av_frame_cluster_interleaver_top_macros.svh
// Assertion macros for the frame cluster interleaver.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef AV_FRAME_CLUSTER_INTERLEAVER_TOP_MACROS_SVH
`define AV_FRAME_CLUSTER_INTERLEAVER_TOP_MACROS_SVH

// Same-cycle implication.
`define AFCI_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AFCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/afci_pkg.sv
// Shared types and constants for the frame cluster interleaver.
// No dependencies.
package afci_pkg;

  localparam int unsigned AFCI_QUEUE_DEPTH = 16;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned END_W  = TIME_W + 1;

  typedef enum logic [1:0] {
    KIND_PUSH_VIDEO = 2'd0,
    KIND_PUSH_AUDIO = 2'd1,
    KIND_DRAIN      = 2'd2,
    KIND_FINISH     = 2'd3
  } afci_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_KEY_AUD,
    ST_PEND_VID,
    ST_FLUSH_AUD,
    ST_FLUSH_VID,
    ST_DONE
  } afci_state_e;

  typedef struct packed {
    logic push_v;
    logic push_a;
    logic drop_v;
    logic drop_a;
    logic pop_v;
    logic pop_a;
    logic new_cluster;
    logic flush;
    logic close;
  } afci_cmd_t;

  typedef struct packed {
    logic v_empty;
    logic a_empty;
    logic v_full;
    logic a_full;
    logic rd_ok;
    logic can_put;
    logic out_free;
    logic pend_v;
    logic v_lt_a;
    logic a_before_v;
    logic v_key;
    logic back_short;
    logic a_le_v;
  } afci_stat_t;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [END_W-1:0]  fend;
    logic              key;
  } afci_ventry_t;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [END_W-1:0]  fend;
  } afci_aentry_t;

  typedef struct packed {
    logic              track;
    logic [TIME_W-1:0] ftime;
    logic [LEN_W-1:0]  flen;
    logic              key;
    logic              opens;
    logic [TIME_W-1:0] span;
    logic              dropped;
  } afci_res_t;

endpackage

// File: hw/rtl/afci_ctrl.sv
// Sequencer for the frame cluster interleaver: merge, flush and result hand-off.
// Depends on afci_pkg and the assertion macro header.
`include "av_frame_cluster_interleaver_top_macros.svh"

module afci_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            kind_i,
  input  afci_pkg::afci_stat_t  stat_i,
  output afci_pkg::afci_cmd_t   cmd_o
);
  import afci_pkg::*;

  afci_state_e state_q, state_d;
  logic        fin_q, fin_d;
  logic        go;

  assign in_stall_o = (state_q != ST_IDLE);
  // head entries loaded and room for a result
  assign go = stat_i.rd_ok && stat_i.can_put;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KIND_PUSH_VIDEO: begin
              if (stat_i.v_full) begin
                cmd_o.drop_v = 1'b1;
                state_d      = ST_DONE;
              end else begin
                cmd_o.push_v = 1'b1;
              end
            end
            KIND_PUSH_AUDIO: begin
              if (stat_i.a_full) begin
                cmd_o.drop_a = 1'b1;
                state_d      = ST_DONE;
              end else begin
                cmd_o.push_a = 1'b1;
              end
            end
            KIND_DRAIN: begin
              fin_d   = 1'b0;
              state_d = ST_EVAL;
            end
            KIND_FINISH: begin
              fin_d   = 1'b1;
              state_d = ST_EVAL;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_EVAL: begin
        if (stat_i.v_empty || stat_i.a_empty) begin
          state_d = fin_q ? ST_FLUSH_AUD : ST_DONE;
        end else if (go) begin
          if (stat_i.v_lt_a) begin
            cmd_o.pop_v = 1'b1;
          end else if (stat_i.a_before_v) begin
            cmd_o.pop_a = 1'b1;
          end else if (stat_i.v_key) begin
            // keyframe waits until queued audio covers it, unless finishing
            if (!fin_q && stat_i.back_short) begin
              state_d = ST_DONE;
            end else begin
              cmd_o.pop_a       = 1'b1;
              cmd_o.new_cluster = 1'b1;
              state_d           = ST_KEY_AUD;
            end
          end else begin
            cmd_o.pop_a = 1'b1;
            state_d     = ST_PEND_VID;
          end
        end
      end
      ST_KEY_AUD: begin
        if (go) begin
          if (!stat_i.a_empty && stat_i.a_le_v) begin
            cmd_o.pop_a = 1'b1;
          end else begin
            cmd_o.pop_v = 1'b1;
            state_d     = ST_EVAL;
          end
        end
      end
      ST_PEND_VID: begin
        if (go) begin
          cmd_o.pop_v = 1'b1;
          state_d     = ST_EVAL;
        end
      end
      ST_FLUSH_AUD: begin
        if (stat_i.a_empty) begin
          state_d = ST_FLUSH_VID;
        end else if (go) begin
          cmd_o.pop_a = 1'b1;
        end
      end
      ST_FLUSH_VID: begin
        if (stat_i.v_empty) begin
          cmd_o.close = 1'b1;
          state_d     = ST_DONE;
        end else if (go) begin
          cmd_o.pop_v       = 1'b1;
          cmd_o.new_cluster = stat_i.v_key;
        end
      end
      ST_DONE: begin
        if (!stat_i.pend_v) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `AFCI_ASSERT(a_pop_v_nonempty, cmd_o.pop_v, !stat_i.v_empty, "video pop from empty queue")
  `AFCI_ASSERT(a_pop_a_nonempty, cmd_o.pop_a, !stat_i.a_empty, "audio pop from empty queue")
  `AFCI_ASSERT(a_pop_ready, cmd_o.pop_v || cmd_o.pop_a, go, "pop before head loaded or room")
  `AFCI_ASSERT_NEXT(a_flush_idle, cmd_o.flush, state_q == ST_IDLE && !stat_i.pend_v, "no hand-off")

endmodule

// File: hw/rtl/afci_dp.sv
// Datapath for the frame cluster interleaver: queue memories, comparisons,
// pending result and output register. Depends on afci_pkg and the macro header.
`include "av_frame_cluster_interleaver_top_macros.svh"

module afci_dp #(
  parameter int unsigned QUEUE_DEPTH = afci_pkg::AFCI_QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  afci_pkg::afci_cmd_t         cmd_i,
  output afci_pkg::afci_stat_t        stat_o,
  input  logic [afci_pkg::TIME_W-1:0] frame_time_i,
  input  logic [afci_pkg::LEN_W-1:0]  frame_length_i,
  input  logic                        is_key_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        track_o,
  output logic [afci_pkg::TIME_W-1:0] out_time_o,
  output logic [afci_pkg::LEN_W-1:0]  out_length_o,
  output logic                        out_key_o,
  output logic                        opens_cluster_o,
  output logic [afci_pkg::TIME_W-1:0] span_end_o,
  output logic                        dropped_o,
  output logic                        last_o
);
  import afci_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  afci_ventry_t v_mem [QUEUE_DEPTH];
  afci_aentry_t a_mem [QUEUE_DEPTH];
  afci_ventry_t v_rd_q, v_wr;
  afci_aentry_t a_rd_q, a_wr;
  logic         rd_ok_q;

  logic [AW-1:0] v_head_q, v_tail_q, a_head_q, a_tail_q;
  logic [CW-1:0] v_cnt_q, a_cnt_q;
  logic [END_W-1:0] in_end, ab_end_q;

  logic              cluster_open_q;
  logic [TIME_W-1:0] span_q, span_d;

  afci_res_t pend_q, out_q, new_res;
  logic      pend_v_q, out_v_q, last_q;
  logic      pop, push, out_free;

  logic [TIME_W-1:0] pop_start;
  logic [LEN_W-1:0]  pop_len;
  logic [END_W-1:0]  pop_end;
  logic [TIME_W-1:0] pop_sat;

  assign pop  = cmd_i.pop_v || cmd_i.pop_a;
  assign push = cmd_i.push_v || cmd_i.push_a;

  assign in_end = {1'b0, frame_time_i} + END_W'(frame_length_i);
  assign v_wr   = '{start: frame_time_i, len: frame_length_i, fend: in_end, key: is_key_i};
  assign a_wr   = '{start: frame_time_i, len: frame_length_i, fend: in_end};

  // queue storage, head read registered every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_v) v_mem[v_tail_q] <= v_wr;
    if (cmd_i.push_a) a_mem[a_tail_q] <= a_wr;
    v_rd_q <= v_mem[v_head_q];
    a_rd_q <= a_mem[a_head_q];
    if (cmd_i.push_a) ab_end_q <= in_end;
  end

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_head_q <= '0;
      v_tail_q <= '0;
      v_cnt_q  <= '0;
      a_head_q <= '0;
      a_tail_q <= '0;
      a_cnt_q  <= '0;
      rd_ok_q  <= 1'b0;
    end else begin
      rd_ok_q <= !(pop || push);
      if (cmd_i.push_v) begin
        v_tail_q <= wrap_inc(v_tail_q);
        v_cnt_q  <= v_cnt_q + 1'b1;
      end else if (cmd_i.pop_v) begin
        v_head_q <= wrap_inc(v_head_q);
        v_cnt_q  <= v_cnt_q - 1'b1;
      end
      if (cmd_i.push_a) begin
        a_tail_q <= wrap_inc(a_tail_q);
        a_cnt_q  <= a_cnt_q + 1'b1;
      end else if (cmd_i.pop_a) begin
        a_head_q <= wrap_inc(a_head_q);
        a_cnt_q  <= a_cnt_q - 1'b1;
      end
    end
  end

  // emitted frame; end saturates at 48 bits for the span
  assign pop_start = cmd_i.pop_v ? v_rd_q.start : a_rd_q.start;
  assign pop_len   = cmd_i.pop_v ? v_rd_q.len   : a_rd_q.len;
  assign pop_end   = cmd_i.pop_v ? v_rd_q.fend  : a_rd_q.fend;
  assign pop_sat   = pop_end[END_W-1] ? '1 : pop_end[TIME_W-1:0];
  assign span_d    = (pop_sat > span_q) ? pop_sat : span_q;

  always_comb begin
    if (pop) begin
      new_res = '{track: cmd_i.pop_a, ftime: pop_start, flen: pop_len,
                  key: cmd_i.pop_v & v_rd_q.key,
                  opens: cmd_i.new_cluster | !cluster_open_q,
                  span: span_d, dropped: 1'b0};
    end else begin
      new_res = '{track: cmd_i.drop_a, ftime: frame_time_i, flen: frame_length_i,
                  key: 1'b0, opens: 1'b0, span: span_q, dropped: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_open_q <= 1'b0;
      span_q         <= '0;
    end else if (pop) begin
      cluster_open_q <= 1'b1;
      span_q         <= span_d;
    end else if (cmd_i.close) begin
      cluster_open_q <= 1'b0;
    end
  end

  // one result is held back so the last one of an item can be marked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if ((pop && pend_v_q) || cmd_i.flush) out_v_q <= 1'b1;
      else if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      if (pop || cmd_i.drop_v || cmd_i.drop_a) pend_v_q <= 1'b1;
      else if (cmd_i.flush) pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || cmd_i.drop_v || cmd_i.drop_a) pend_q <= new_res;
    if ((pop && pend_v_q) || cmd_i.flush) begin
      out_q  <= pend_q;
      last_q <= cmd_i.flush;
    end
  end

  assign out_free = !out_v_q || !out_stall_i;

  assign stat_o.v_empty    = (v_cnt_q == '0);
  assign stat_o.a_empty    = (a_cnt_q == '0);
  assign stat_o.v_full     = (v_cnt_q == CW'(QUEUE_DEPTH));
  assign stat_o.a_full     = (a_cnt_q == CW'(QUEUE_DEPTH));
  assign stat_o.rd_ok      = rd_ok_q;
  assign stat_o.out_free   = out_free;
  assign stat_o.can_put    = !pend_v_q || out_free;
  assign stat_o.pend_v     = pend_v_q;
  assign stat_o.v_lt_a     = (v_rd_q.start < a_rd_q.start);
  assign stat_o.a_before_v = (a_rd_q.start < v_rd_q.start) &&
                             (a_rd_q.fend <= {1'b0, v_rd_q.start});
  assign stat_o.v_key      = v_rd_q.key;
  assign stat_o.back_short = (ab_end_q < v_rd_q.fend);
  assign stat_o.a_le_v     = (a_rd_q.start <= v_rd_q.start);

  assign out_valid_o     = out_v_q;
  assign track_o         = out_q.track;
  assign out_time_o      = out_q.ftime;
  assign out_length_o    = out_q.flen;
  assign out_key_o       = out_q.key;
  assign opens_cluster_o = out_q.opens;
  assign span_end_o      = out_q.span;
  assign dropped_o       = out_q.dropped;
  assign last_o          = last_q;

  `AFCI_ASSERT(a_v_cnt_bound, 1'b1, v_cnt_q <= CW'(QUEUE_DEPTH), "video count above depth")
  `AFCI_ASSERT(a_a_cnt_bound, 1'b1, a_cnt_q <= CW'(QUEUE_DEPTH), "audio count above depth")
  `AFCI_ASSERT(a_no_overwrite, (pop && pend_v_q) || cmd_i.flush, out_free, "output overwritten")
  `AFCI_ASSERT_NEXT(a_cluster_after_pop, pop, cluster_open_q, "cluster not open after frame")

endmodule

// File: hw/rtl/av_frame_cluster_interleaver_top.sv
// A push is taken while idle; a rejected push's result moves from the pending register to the
// output register once the output is free. Drain/finish: frames pop once the registered head read
// has reloaded and a result can be placed, then the last result is handed off; one item at a time.
// Reset (async, active low) clears queue pointers, counts, cluster flag, span and handshakes.
// Queue memories are not cleared; only entries written by pushes are ever read.
// Top level: controller plus datapath joined by command and status structs.
module av_frame_cluster_interleaver_top #(
  parameter int unsigned QUEUE_DEPTH = afci_pkg::AFCI_QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [afci_pkg::TIME_W-1:0] frame_time_i,
  input  logic [afci_pkg::LEN_W-1:0]  frame_length_i,
  input  logic                        is_key_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        track_o,
  output logic [afci_pkg::TIME_W-1:0] out_time_o,
  output logic [afci_pkg::LEN_W-1:0]  out_length_o,
  output logic                        out_key_o,
  output logic                        opens_cluster_o,
  output logic [afci_pkg::TIME_W-1:0] span_end_o,
  output logic                        dropped_o,
  output logic                        last_o
);
  import afci_pkg::*;

  afci_cmd_t  cmd;
  afci_stat_t stat;

  afci_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  afci_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .frame_time_i    (frame_time_i),
    .frame_length_i  (frame_length_i),
    .is_key_i        (is_key_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .track_o         (track_o),
    .out_time_o      (out_time_o),
    .out_length_o    (out_length_o),
    .out_key_o       (out_key_o),
    .opens_cluster_o (opens_cluster_o),
    .span_end_o      (span_end_o),
    .dropped_o       (dropped_o),
    .last_o          (last_o)
  );

endmodule
